FILE: rtl/sauv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sauv_pkg
// Shared constants and types for the sprite atlas frame rectangle lookup.
// ----------------------------------------------------------------------------
package sauv_pkg;

	localparam int unsigned OUT_W     = 18;
	localparam int unsigned SIDE_W    = 15;
	localparam int unsigned RECIP_W   = 33;
	localparam int unsigned TWICE_W   = 25;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 17;

	localparam logic [SIDE_W-1:0] MAX_TEX_SIDE = 15'd16384;
	localparam logic [8:0]        MAX_GRID     = 9'd256;
	localparam logic [OUT_W-1:0]  OUT_MAX      = {OUT_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEX_W   = 3'd0,
		REG_TEX_H   = 3'd1,
		REG_COLS    = 3'd2,
		REG_ROWS    = 3'd3,
		REG_FRAMES  = 3'd4,
		REG_FRAME_W = 3'd5,
		REG_FRAME_H = 3'd6,
		REG_GUTTER  = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SU_LOAD,
		SU_DIV,
		SU_IDLE
	} setup_state_t;

	typedef enum logic [2:0] {
		STEP_FW    = 3'd0,
		STEP_FH    = 3'd1,
		STEP_RCOL  = 3'd2,
		STEP_RTW   = 3'd3,
		STEP_RTH   = 3'd4,
		STEP_USIZE = 3'd5,
		STEP_VSIZE = 3'd6
	} setup_step_t;

endpackage

`default_nettype wire

FILE: rtl/sauv_fixdiv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sauv_fixdiv
// Five-stage pipelined floor(twice * 2^15 / side) with saturation, using a
// precomputed reciprocal floor(2^32 / side) and one correction step.
// ----------------------------------------------------------------------------
module sauv_fixdiv
	import sauv_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               adv,
	input  wire logic [TWICE_W-1:0] twice,
	input  wire logic [SIDE_W-1:0]  side,
	input  wire logic [RECIP_W-1:0] recip,
	output logic      [OUT_W-1:0]   quo
);

	logic                sat_s1, sat_s2, sat_s3, sat_s4;
	logic [16:0]         n_s1, n_s2, n_s3;
	logic [48:0]         plo_s2;
	logic [RECIP_W-1:0]  phi_s2;
	logic [OUT_W-1:0]    q_s3, q_s4;
	logic [15:0]         r_s4;
	logic [49:0]         prod;
	logic [32:0]         qside;
	logic [32:0]         rfull;

	assign prod  = {1'b0, plo_s2} + {1'b0, phi_s2, 16'b0};
	assign qside = {15'b0, q_s3} * {18'b0, side};
	assign rfull = {1'b0, n_s3, 15'b0} - qside;

	always_ff @(posedge clk) begin
		if (adv) begin
			sat_s1 <= twice >= {7'b0, side, 3'b0};
			n_s1   <= twice[16:0];

			sat_s2 <= sat_s1;
			n_s2   <= n_s1;
			plo_s2 <= {16'b0, n_s1[15:0]} * {16'b0, recip};
			phi_s2 <= n_s1[16] ? recip : '0;

			sat_s3 <= sat_s2;
			n_s3   <= n_s2;
			q_s3   <= prod[34:17];

			sat_s4 <= sat_s3;
			q_s4   <= q_s3;
			r_s4   <= rfull[15:0];

			if (sat_s4)
				quo <= OUT_MAX;
			else if (r_s4 >= {1'b0, side})
				quo <= q_s4 + 1'b1;
			else
				quo <= q_s4;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sprite_atlas_frame_uv_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_atlas_frame_uv_top
// Frame index to normalized texture rectangle lookup for a sprite grid.
// ----------------------------------------------------------------------------
// One item is taken per cycle and the pipeline stalls as a whole when the
// result is not taken. After reset and after every register write a setup
// sequencer works out the layout with one shared radix-2 divider: a load
// step and then seven divisions, during which s_tready stays low.
module sprite_atlas_frame_uv_top
	import sauv_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [15:0]          s_tdata,  // frame_index
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [71:0]          m_tdata   // u_start, v_start, u_size, v_size
);

	localparam int unsigned DEPTH = 10;

	logic [14:0] tex_w_q, tex_h_q, set_w_q, set_h_q;
	logic [8:0]  cols_reg_q, rows_reg_q;
	logic [16:0] limit_q, gutter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_w_q    <= '0;
			tex_h_q    <= '0;
			cols_reg_q <= 9'd1;
			rows_reg_q <= 9'd1;
			limit_q    <= '0;
			set_w_q    <= '0;
			set_h_q    <= '0;
			gutter_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TEX_W:   tex_w_q    <= cfg_data[14:0];
				REG_TEX_H:   tex_h_q    <= cfg_data[14:0];
				REG_COLS:    cols_reg_q <= cfg_data[8:0];
				REG_ROWS:    rows_reg_q <= cfg_data[8:0];
				REG_FRAMES:  limit_q    <= cfg_data;
				REG_FRAME_W: set_w_q    <= cfg_data[14:0];
				REG_FRAME_H: set_h_q    <= cfg_data[14:0];
				REG_GUTTER:  gutter_q   <= cfg_data;
				default:     ;
			endcase
		end
	end

	// layout values seen by the setup load
	logic [14:0] tw_c, th_c, inner_w, inner_h, num_w, num_h;
	logic [8:0]  cols_c, rows_c;
	logic [7:0]  margin_c, pad_c;
	logic [8:0]  margin2_c;
	logic [15:0] gaps_w, gaps_h;
	logic [17:0] cells_c;
	logic [16:0] frames_c;

	assign tw_c      = (tex_w_q > MAX_TEX_SIDE) ? MAX_TEX_SIDE : tex_w_q;
	assign th_c      = (tex_h_q > MAX_TEX_SIDE) ? MAX_TEX_SIDE : tex_h_q;
	assign cols_c    = (cols_reg_q == 9'd0) ? 9'd1 : (cols_reg_q > MAX_GRID) ? MAX_GRID : cols_reg_q;
	assign rows_c    = (rows_reg_q == 9'd0) ? 9'd1 : (rows_reg_q > MAX_GRID) ? MAX_GRID : rows_reg_q;
	assign margin_c  = gutter_q[7:0];
	assign pad_c     = gutter_q[15:8];
	assign margin2_c = {margin_c, 1'b0};
	assign cells_c   = {9'b0, cols_c} * {9'b0, rows_c};
	assign frames_c  = (limit_q == 17'd0 || {1'b0, limit_q} > cells_c) ? cells_c[16:0] : limit_q;
	assign gaps_w    = {8'b0, cols_c[7:0] - 8'd1} * {8'b0, pad_c};
	assign gaps_h    = {8'b0, rows_c[7:0] - 8'd1} * {8'b0, pad_c};
	assign inner_w   = (tw_c > {6'b0, margin2_c}) ? tw_c - {6'b0, margin2_c} : tw_c;
	assign inner_h   = (th_c > {6'b0, margin2_c}) ? th_c - {6'b0, margin2_c} : th_c;
	assign num_w     = ({1'b0, inner_w} > gaps_w) ? inner_w - gaps_w[14:0] : tw_c;
	assign num_h     = ({1'b0, inner_h} > gaps_h) ? inner_h - gaps_h[14:0] : th_c;

	// setup sequencer
	setup_state_t state_q, state_d;
	setup_step_t  step_q;
	logic [5:0]   cnt_q;
	logic [32:0]  dnum_q;
	logic [15:0]  drem_q;
	logic [14:0]  dden_q;
	logic         do_load, do_init, do_iter, do_capture, last_step;

	logic [14:0] tw_q, th_q, numw_q, numh_q, fsw_q, fsh_q, fw_q, fh_q;
	logic [8:0]  cols_q, rows_q;
	logic [16:0] frames_q;
	logic [7:0]  margin_q, pad_q;
	logic        inset_q, zero_q;
	logic [15:0] pitch_w_q, pitch_h_q;
	logic [24:0] rcol_q;
	logic [RECIP_W-1:0] rtw_q, rth_q;
	logic [OUT_W-1:0]   usize_q, vsize_q;

	logic [32:0] op_num;
	logic [14:0] op_den;
	logic [15:0] dw_c, dh_c;
	logic [15:0] rem_sh;
	logic [14:0] q_lo;

	assign dw_c = (fw_q == 15'd1 && inset_q) ? 16'd1 : {fw_q, 1'b0} - {14'b0, inset_q, 1'b0};
	assign dh_c = (fh_q == 15'd1 && inset_q) ? 16'd1 : {fh_q, 1'b0} - {14'b0, inset_q, 1'b0};
	assign last_step = (step_q == STEP_VSIZE);
	assign rem_sh    = {drem_q[14:0], dnum_q[32]};
	assign q_lo      = (dnum_q[14:0] == 15'd0) ? 15'd1 : dnum_q[14:0];

	always_comb begin
		op_num = '0;
		op_den = '0;
		case (step_q)
			STEP_FW:    begin op_num = {18'b0, numw_q}; op_den = {6'b0, cols_q}; end
			STEP_FH:    begin op_num = {18'b0, numh_q}; op_den = {6'b0, rows_q}; end
			STEP_RCOL:  begin op_num = 33'h1000000;     op_den = {6'b0, cols_q}; end
			STEP_RTW:   begin op_num = 33'h100000000;   op_den = tw_q; end
			STEP_RTH:   begin op_num = 33'h100000000;   op_den = th_q; end
			STEP_USIZE: begin op_num = {2'b0, dw_c, 15'b0}; op_den = tw_q; end
			STEP_VSIZE: begin op_num = {2'b0, dh_c, 15'b0}; op_den = th_q; end
			default:    ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			SU_LOAD: state_d = SU_DIV;
			SU_DIV:  if (cnt_q == 6'd34 && last_step) state_d = SU_IDLE;
			SU_IDLE: state_d = SU_IDLE;
			default: state_d = SU_LOAD;
		endcase
		if (cfg_we)
			state_d = SU_LOAD;
	end

	always_comb begin
		do_load    = (state_q == SU_LOAD);
		do_init    = (state_q == SU_DIV) && (cnt_q == 6'd0);
		do_iter    = (state_q == SU_DIV) && (cnt_q != 6'd0) && (cnt_q != 6'd34);
		do_capture = (state_q == SU_DIV) && (cnt_q == 6'd34);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SU_LOAD;
			step_q  <= STEP_FW;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we || do_load) begin
				step_q <= STEP_FW;
				cnt_q  <= '0;
			end else if (do_capture) begin
				step_q <= setup_step_t'(step_q + 3'd1);
				cnt_q  <= '0;
			end else if (state_q == SU_DIV) begin
				cnt_q <= cnt_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			tw_q     <= tw_c;
			th_q     <= th_c;
			cols_q   <= cols_c;
			rows_q   <= rows_c;
			frames_q <= frames_c;
			numw_q   <= num_w;
			numh_q   <= num_h;
			fsw_q    <= set_w_q;
			fsh_q    <= set_h_q;
			margin_q <= margin_c;
			pad_q    <= pad_c;
			inset_q  <= gutter_q[16];
			zero_q   <= (tw_c == 15'd0) || (th_c == 15'd0);
		end
		if (do_init) begin
			dnum_q <= op_num;
			drem_q <= '0;
			dden_q <= op_den;
		end else if (do_iter) begin
			if (rem_sh >= {1'b0, dden_q}) begin
				drem_q <= rem_sh - {1'b0, dden_q};
				dnum_q <= {dnum_q[31:0], 1'b1};
			end else begin
				drem_q <= rem_sh;
				dnum_q <= {dnum_q[31:0], 1'b0};
			end
		end
		if (do_capture) begin
			case (step_q)
				STEP_FW: begin
					fw_q      <= (fsw_q != 15'd0) ? fsw_q : q_lo;
					pitch_w_q <= {1'b0, (fsw_q != 15'd0) ? fsw_q : q_lo} + {8'b0, pad_q};
				end
				STEP_FH: begin
					fh_q      <= (fsh_q != 15'd0) ? fsh_q : q_lo;
					pitch_h_q <= {1'b0, (fsh_q != 15'd0) ? fsh_q : q_lo} + {8'b0, pad_q};
				end
				STEP_RCOL:  rcol_q  <= dnum_q[24:0];
				STEP_RTW:   rtw_q   <= dnum_q;
				STEP_RTH:   rth_q   <= dnum_q;
				STEP_USIZE: usize_q <= (dnum_q > {15'b0, OUT_MAX}) ? OUT_MAX : dnum_q[17:0];
				STEP_VSIZE: vsize_q <= (dnum_q > {15'b0, OUT_MAX}) ? OUT_MAX : dnum_q[17:0];
				default:    ;
			endcase
		end
	end

	// item pipeline
	logic [DEPTH-1:0] vld_q;
	logic             adv;

	assign adv      = !vld_q[DEPTH-1] || m_tready;
	assign s_tready = adv && (state_q == SU_IDLE);
	assign m_tvalid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[DEPTH-2:0], s_tvalid && s_tready};
	end

	logic [15:0] idx_s1, idx_s2, q_s2, q_s3;
	logic [9:0]  r_s3;
	logic [7:0]  col_s4, row_s4;
	logic [TWICE_W-1:0] tu_s5, tv_s5;
	logic [40:0] qprod;
	logic [24:0] qcols;
	logic [24:0] rdiff;
	logic        ge_c;
	logic [23:0] px_c, py_c;

	assign qprod = {25'b0, idx_s1} * {16'b0, rcol_q};
	assign qcols = {9'b0, q_s2} * {16'b0, cols_q};
	assign rdiff = {9'b0, idx_s2} - qcols;
	assign ge_c  = r_s3 >= {1'b0, cols_q};
	assign px_c  = {8'b0, margin_q} + {16'b0, col_s4} * {8'b0, pitch_w_q};
	assign py_c  = {8'b0, margin_q} + {16'b0, row_s4} * {8'b0, pitch_h_q};

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1 <= ({1'b0, s_tdata} >= frames_q) ? 16'(frames_q - 17'd1) : s_tdata;

			idx_s2 <= idx_s1;
			q_s2   <= qprod[39:24];

			q_s3   <= q_s2;
			r_s3   <= rdiff[9:0];

			col_s4 <= ge_c ? 8'(r_s3 - {1'b0, cols_q}) : r_s3[7:0];
			row_s4 <= q_s3[7:0] + {7'b0, ge_c};

			tu_s5  <= {px_c, inset_q};
			tv_s5  <= {py_c, inset_q};
		end
	end

	logic [OUT_W-1:0] u_start, v_start;

	sauv_fixdiv u_div (
		.clk   (clk),
		.adv   (adv),
		.twice (tu_s5),
		.side  (tw_q),
		.recip (rtw_q),
		.quo   (u_start)
	);

	sauv_fixdiv v_div (
		.clk   (clk),
		.adv   (adv),
		.twice (tv_s5),
		.side  (th_q),
		.recip (rth_q),
		.quo   (v_start)
	);

	assign m_tdata = zero_q ? 72'd0 : {vsize_q, usize_q, v_start, u_start};

	a_setup_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != SU_IDLE) |-> !s_tready)
		else $error("item taken during setup");

	a_write_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (state_q == SU_LOAD) && !s_tready)
		else $error("register write did not restart setup");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[3] |-> ({1'b0, col_s4} < cols_q))
		else $error("column out of grid");

	a_zero_tex: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && zero_q) |-> (m_tdata == 72'd0))
		else $error("nonzero rectangle without texture");

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sprite atlas frame rectangle lookup: computes
// each expected rectangle from the register settings, streams frame indexes
// with random gaps and back-pressure, and compares every returned rectangle.
// ----------------------------------------------------------------------------
class rect_board;
	logic [71:0] pending_rects[$];
	int errors;

	function void note_index(logic [71:0] rect);
		pending_rects.insert(pending_rects.size(), rect);
	endfunction

	function void check_rect(logic [71:0] got);
		logic [71:0] want;
		if (pending_rects.size() == 0) begin
			$display("%0t unexpected rect got=%h", $time, got);
			errors++;
			return;
		end
		want = pending_rects.pop_front();
		for (int f = 0; f < 4; f++) begin
			if (want[f*18 +: 18] !== got[f*18 +: 18]) begin
				$display("%0t field %0d exp=%h act=%h", $time, f,
					want[f*18 +: 18], got[f*18 +: 18]);
				errors++;
			end
		end
	endfunction
endclass

module tb;
	import sauv_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [15:0]          s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [71:0]          m_tdata;

	logic [16:0] regs[8];
	rect_board board;
	longint cycles;
	bit bp_mode;

	sprite_atlas_frame_uv_top u_dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint clamp_grid(longint v);
		if (v < 1) return 1;
		if (v > 256) return 256;
		return v;
	endfunction

	function automatic longint frame_side(longint setting, longint side, longint count,
			longint margin, longint padding);
		longint f, inner, gaps;
		if (setting > 0) f = setting;
		else begin
			inner = (side > 2 * margin) ? side - 2 * margin : side;
			gaps = (count - 1) * padding;
			f = (inner > gaps) ? (inner - gaps) / count : side / count;
		end
		return f < 1 ? 1 : f;
	endfunction

	function automatic longint norm(longint twice, longint side);
		longint q;
		q = (twice << 15) / side;
		return q > 262143 ? 262143 : q;
	endfunction

	function automatic logic [71:0] frame_rect(logic [15:0] index);
		longint tw, th, cols, rows, cells, frames, margin, padding, inset;
		longint fw, fh, idx, px, py, dw, dh;
		logic [71:0] r;
		tw = regs[REG_TEX_W]; th = regs[REG_TEX_H];
		cols = clamp_grid(regs[REG_COLS]); rows = clamp_grid(regs[REG_ROWS]);
		cells = cols * rows;
		frames = regs[REG_FRAMES] == 0 ? cells : regs[REG_FRAMES];
		margin = regs[REG_GUTTER][7:0];
		padding = regs[REG_GUTTER][15:8];
		inset = regs[REG_GUTTER][16];
		if (tw > 16384) tw = 16384;
		if (th > 16384) th = 16384;
		if (frames > cells) frames = cells;
		if (tw == 0 || th == 0) return '0;
		fw = frame_side(regs[REG_FRAME_W], tw, cols, margin, padding);
		fh = frame_side(regs[REG_FRAME_H], th, rows, margin, padding);
		idx = index;
		if (idx >= frames) idx = frames - 1;
		px = margin + (idx % cols) * (fw + padding);
		py = margin + (idx / cols) * (fh + padding);
		dw = 2 * fw - 2 * inset;
		if (dw < inset) dw = inset;
		dh = 2 * fh - 2 * inset;
		if (dh < inset) dh = inset;
		r[17:0] = 18'(norm(2 * px + inset, tw));
		r[35:18] = 18'(norm(2 * py + inset, th));
		r[53:36] = 18'(norm(dw, tw));
		r[71:54] = 18'(norm(dh, th));
		return r;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 2) == 0) return 0;
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [16:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		regs[idx] = val & ((idx inside {REG_COLS, REG_ROWS}) ? 17'h1ff :
			(idx inside {REG_FRAMES, REG_GUTTER}) ? 17'h1ffff : 17'h7fff);
	endtask

	task automatic send_index(logic [15:0] index);
		int g;
		g = bp_mode ? gap_len() : 0;
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= index;
		do @(posedge clk); while (!s_tready);
		board.note_index(frame_rect(index));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending_rects.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic apply_layout(logic [16:0] v[8]);
		for (int i = 0; i < 8; i++) write_reg(cfg_reg_t'(i), v[i]);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [16:0] pick(int hi);
		case ($urandom_range(0, 3))
			0: return 17'd0;
			1: return 17'(hi);
			default: return 17'($urandom_range(0, hi));
		endcase
	endfunction

	always @(posedge clk) begin
		if (m_tvalid && m_tready) board.check_rect(m_tdata);
		m_tready <= bp_mode ? (($urandom_range(0, 9) == 0) ? 1'b0 :
			($urandom_range(0, 3) != 0)) : 1'b1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("[sprite_atlas_frame_uv_top] ERROR");
			$finish;
		end
	end

	initial begin
		logic [16:0] v[8];
		int n;
		board = new();
		cycles = 0;
		bp_mode = 0;
		cfg_we = 0; cfg_index = '0; cfg_data = '0;
		s_tvalid = 0; s_tdata = '0; m_tready = 0;
		regs = '{0, 0, 1, 1, 0, 0, 0, 0};
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;

		// No texture after reset
		send_index(0);
		send_index(16'hffff);
		drain();

		v = '{256, 128, 16, 8, 0, 0, 0, 17'h10201};
		apply_layout(v);
		send_index(0); send_index(1); send_index(15); send_index(16);
		send_index(127); send_index(128); send_index(16'hffff); send_index(16'haaaa);
		send_index(16'h5555);
		drain();

		v = '{32767, 16384, 511, 0, 65536, 16384, 16384, 17'h1ffff};
		apply_layout(v);
		send_index(0); send_index(255); send_index(16'hffff); send_index(300);
		drain();

		v = '{1, 3, 256, 256, 1, 0, 0, 17'h10000};
		apply_layout(v);
		send_index(0); send_index(16'hffff);
		drain();
		write_reg(REG_FRAMES, 17'h1ffff);
		write_reg(REG_GUTTER, 17'h0ff00);
		cfg_we <= 1'b0;
		send_index(16'hffff); send_index(256);
		drain();

		for (int ph = 0; ph < 27; ph++) begin
			bp_mode = (ph % 4) != 0;
			v[REG_TEX_W] = ($urandom_range(0, 9) == 0) ? pick(32767) :
				17'($urandom_range(1, 17000));
			v[REG_TEX_H] = ($urandom_range(0, 9) == 0) ? pick(32767) :
				17'($urandom_range(1, 17000));
			v[REG_COLS] = pick(511);
			v[REG_ROWS] = ($urandom_range(0, 3) == 0) ? pick(511) :
				17'($urandom_range(1, 20));
			v[REG_FRAMES] = $urandom_range(0, 1) ? 17'd0 : pick(17'h1ffff);
			v[REG_FRAME_W] = $urandom_range(0, 1) ? 17'd0 : pick(32767);
			v[REG_FRAME_H] = $urandom_range(0, 1) ? 17'd0 : pick(32767);
			v[REG_GUTTER] = pick(17'h1ffff);
			apply_layout(v);
			for (n = 0; n < 50; n++) begin
				case ($urandom_range(0, 3))
					0: send_index(16'($urandom()));
					1: send_index(16'($urandom_range(0, 600)));
					default: send_index(16'($urandom_range(0, 64)));
				endcase
			end
			drain();
		end

		bp_mode = 0;
		drain();
		if (board.errors == 0 && board.pending_rects.size() == 0)
			$display("[sprite_atlas_frame_uv_top] OK");
		else
			$display("[sprite_atlas_frame_uv_top] ERROR");
		$finish;
	end
endmodule
